>>> design/ppr_pkg.sv
// shared types and constants of the video processor cpu register port
`default_nettype none

package ppr_pkg;

    // bus commands carried by an input item
    typedef enum logic [1:0] {
        CMD_READ      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_VBL_BEGIN = 2'd2,
        CMD_VBL_END   = 2'd3
    } t_cmd;

    // register numbers (cpu address bits 2..0)
    localparam logic [2:0] REG_CTRL      = 3'd0;
    localparam logic [2:0] REG_MASK      = 3'd1;
    localparam logic [2:0] REG_STATUS    = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
    localparam logic [2:0] REG_OAM_DATA  = 3'd4;
    localparam logic [2:0] REG_SCROLL    = 3'd5;
    localparam logic [2:0] REG_ADDR      = 3'd6;
    localparam logic [2:0] REG_DATA      = 3'd7;

    // sprite attribute memory geometry
    localparam int SPR_DEPTH = 256;
    localparam int SPR_AW    = $clog2(SPR_DEPTH);

    // palette geometry and masks
    localparam int          PAL_DEPTH     = 32;
    localparam int          PAL_AW        = $clog2(PAL_DEPTH);
    localparam logic [5:0]  PAL_PAGE      = 6'h3F;
    localparam logic [7:0]  PAL_MASK_GRAY = 8'h30;
    localparam logic [7:0]  PAL_MASK_FULL = 8'h3F;
    localparam logic [7:0]  SPR_ATTR_MASK = 8'hE3;

    // one accepted input item
    typedef struct packed {
        t_cmd        command;
        logic [2:0]  reg_select;
        logic [7:0]  write_byte;
        logic [7:0]  vram_byte;
    } t_item;

    // one result item
    typedef struct packed {
        logic [7:0]  read_byte;
        logic        nmi_level;
        logic [13:0] vram_address;
        logic        vram_write_enable;
        logic [7:0]  vram_write_byte;
    } t_result;

endpackage

`default_nettype wire

>>> design/ppr_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module ppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, a write to the read address passes straight through
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/ppr_palette.sv
// 32-entry palette store with backdrop entry mirroring
`default_nettype none

module ppr_palette import ppr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [PAL_AW-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic [PAL_AW-1:0] i_raddr,
    output      logic [7:0]        o_rdata
);

    logic [PAL_AW-1:0] widx;
    logic [PAL_AW-1:0] ridx;

    // entries 0x10/0x14/0x18/0x1c alias their lower-half partners
    function automatic logic [PAL_AW-1:0] fold_mirror(input logic [PAL_AW-1:0] a);
        logic [PAL_AW-1:0] f;
        f = a;
        if (a[4] && (a[1:0] == 2'b00)) begin
            f[4] = 1'b0;
        end
        return f;
    endfunction

    assign widx = fold_mirror(i_waddr);
    assign ridx = fold_mirror(i_raddr);

    ppr_ram #(
        .WIDTH (8),
        .DEPTH (PAL_DEPTH)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (widx),
        .i_wdata (i_wdata),
        .i_raddr (ridx),
        .o_rdata (o_rdata)
    );

endmodule

`default_nettype wire

>>> design/ppr_core.sv
// register state, per-item update logic and result register
`default_nettype none

module ppr_core import ppr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire t_item   i_item,
    output      t_result o_result
);

    logic [7:0]        r_ctrl, n_ctrl;
    logic [7:0]        r_mask, n_mask;
    logic [2:0]        r_status, n_status;
    logic [SPR_AW-1:0] r_ptr, n_ptr;
    logic [7:0]        r_rbuf, n_rbuf;
    logic [14:0]       r_v, n_v;
    logic [14:0]       r_t, n_t;
    logic [2:0]        r_fine_x, n_fine_x;
    logic              r_toggle, n_toggle;
    logic [7:0]        r_latch, n_latch;
    t_result           r_res, n_res;

    logic              is_pal;
    logic [14:0]       v_inc;
    logic [7:0]        pal_rd, pal_byte;
    logic              pal_we;
    logic [7:0]        spr_rd, spr_byte;
    logic              spr_we;
    logic              ext_we;
    logic [7:0]        d;

    assign d      = i_item.write_byte;
    assign is_pal = (r_v[13:8] == PAL_PAGE);
    assign v_inc  = r_v + (r_ctrl[2] ? 15'd32 : 15'd1);

    // sprite attribute memory, read address follows the next pointer
    ppr_ram #(
        .WIDTH (8),
        .DEPTH (SPR_DEPTH)
    ) u_spr_ram (
        .i_clk   (i_clk),
        .i_we    (spr_we),
        .i_waddr (r_ptr),
        .i_wdata (d),
        .i_raddr (n_ptr),
        .o_rdata (spr_rd)
    );

    // palette store, written at the current address, read address follows the next one
    ppr_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_v[PAL_AW-1:0]),
        .i_wdata (d),
        .i_raddr (n_v[PAL_AW-1:0]),
        .o_rdata (pal_rd)
    );

    assign pal_byte = pal_rd & (r_mask[0] ? PAL_MASK_GRAY : PAL_MASK_FULL);
    assign spr_byte = (r_ptr[1:0] == 2'd2) ? (spr_rd & SPR_ATTR_MASK) : spr_rd;

    // next state for one item
    always_comb begin
        n_ctrl   = r_ctrl;
        n_mask   = r_mask;
        n_status = r_status;
        n_ptr    = r_ptr;
        n_rbuf   = r_rbuf;
        n_v      = r_v;
        n_t      = r_t;
        n_fine_x = r_fine_x;
        n_toggle = r_toggle;
        n_latch  = r_latch;
        pal_we   = 1'b0;
        spr_we   = 1'b0;
        ext_we   = 1'b0;
        if (i_fire) begin
            unique case (i_item.command)
                CMD_READ: begin
                    unique case (i_item.reg_select)
                        REG_STATUS: begin
                            n_latch     = {r_status, r_latch[4:0]};
                            n_status[2] = 1'b0;
                            n_toggle    = 1'b0;
                        end
                        REG_OAM_DATA: begin
                            n_latch = spr_byte;
                        end
                        REG_DATA: begin
                            if (is_pal) begin
                                n_latch = {r_latch[7:6], pal_byte[5:0]};
                            end else begin
                                n_latch = r_rbuf;
                            end
                            n_rbuf = i_item.vram_byte;
                            n_v    = v_inc;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_WRITE: begin
                    n_latch = d;
                    unique case (i_item.reg_select)
                        REG_CTRL: begin
                            n_ctrl       = d;
                            n_t[11:10]   = d[1:0];
                        end
                        REG_MASK: begin
                            n_mask = d;
                        end
                        REG_OAM_ADDR: begin
                            n_ptr = d;
                        end
                        REG_OAM_DATA: begin
                            spr_we = 1'b1;
                            n_ptr  = r_ptr + SPR_AW'(1);
                        end
                        REG_SCROLL: begin
                            if (!r_toggle) begin
                                n_t[4:0] = d[7:3];
                                n_fine_x = d[2:0];
                                n_toggle = 1'b1;
                            end else begin
                                n_t[14:12] = d[2:0];
                                n_t[9:5]   = d[7:3];
                                n_toggle   = 1'b0;
                            end
                        end
                        REG_ADDR: begin
                            if (!r_toggle) begin
                                n_t[14]   = 1'b0;
                                n_t[13:8] = d[5:0];
                                n_toggle  = 1'b1;
                            end else begin
                                n_t      = {r_t[14:8], d};
                                n_v      = {r_t[14:8], d};
                                n_toggle = 1'b0;
                            end
                        end
                        REG_DATA: begin
                            if (is_pal) begin
                                pal_we = 1'b1;
                            end else begin
                                ext_we = 1'b1;
                            end
                            n_v = v_inc;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_VBL_BEGIN: begin
                    n_status[2] = 1'b1;
                end
                CMD_VBL_END: begin
                    n_status = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // result item built from the updated state, with the current address for an external write
    always_comb begin
        n_res.read_byte         = n_latch;
        n_res.nmi_level         = n_ctrl[7] & n_status[2];
        n_res.vram_address      = ext_we ? r_v[13:0] : n_v[13:0];
        n_res.vram_write_enable = ext_we;
        n_res.vram_write_byte   = ext_we ? d : 8'h00;
    end

    // control and scroll state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_mask   <= '0;
            r_status <= '0;
            r_ptr    <= '0;
            r_rbuf   <= '0;
            r_v      <= '0;
            r_t      <= '0;
            r_fine_x <= '0;
            r_toggle <= 1'b0;
            r_latch  <= '0;
        end else begin
            r_ctrl   <= n_ctrl;
            r_mask   <= n_mask;
            r_status <= n_status;
            r_ptr    <= n_ptr;
            r_rbuf   <= n_rbuf;
            r_v      <= n_v;
            r_t      <= n_t;
            r_fine_x <= n_fine_x;
            r_toggle <= n_toggle;
            r_latch  <= n_latch;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

>>> design/ppu_cpu_register_port.sv
// Video processor cpu register port: one bus access or vblank event per item.
// Items pass an input register, then one stage that updates all register
// state and loads the result register, so a new item is taken every cycle
// unless the output side stalls. A result is presented once its item has
// passed the input register and the update stage, and is taken when the
// output side is ready; while a result waits, one more item is held in
// the input register and then the input side stalls. The sprite attribute
// memory (256 bytes) and the palette (32 bytes) are rams whose read ports
// track the next sprite pointer and the next address, so their data is
// ready when a read item reaches the update stage. Sprite and palette
// contents are undefined until written; there is no clearing pass after reset.
`default_nettype none

module ppu_cpu_register_port import ppr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [2:0]  i_reg_select,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic [7:0]  i_vram_byte,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [7:0]  o_read_byte,
    output      logic        o_nmi_level,
    output      logic [13:0] o_vram_address,
    output      logic        o_vram_write_enable,
    output      logic [7:0]  o_vram_write_byte
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    logic    fire;
    t_result res;

    // item moves into the result register when that register is free or drains
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.command    <= t_cmd'(i_command);
            r_item.reg_select <= i_reg_select;
            r_item.write_byte <= i_write_byte;
            r_item.vram_byte  <= i_vram_byte;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    ppr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .o_result (res)
    );

    assign o_out_valid         = r_out_valid;
    assign o_read_byte         = res.read_byte;
    assign o_nmi_level         = res.nmi_level;
    assign o_vram_address      = res.vram_address;
    assign o_vram_write_enable = res.vram_write_enable;
    assign o_vram_write_byte   = res.vram_write_byte;

`ifndef SYNTHESIS
    // palette range writes never reach external memory
    a_no_ext_pal_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_vram_write_enable) |-> (o_vram_address[13:8] != PAL_PAGE))
        else $error("external write inside palette range");

    // write byte is zero when no external write happens
    a_idle_write_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_vram_write_enable) |-> (o_vram_write_byte == 8'h00))
        else $error("write byte driven without write enable");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
